### rtl/eco_pkg.sv
// Package for the camera orientation unit: command codes, CORDIC constants,
// the arctangent table and shared types. No dependencies.
`timescale 1ns / 1ps
package eco_pkg;

  typedef enum logic [2:0] {
    KIND_SET_POS  = 3'd0,
    KIND_SET_ROT  = 3'd1,
    KIND_ROTATE   = 3'd2,
    KIND_FORWARD  = 3'd3,
    KIND_RIGHT    = 3'd4,
    KIND_UP       = 3'd5,
    KIND_RST_ROT  = 3'd6,
    KIND_REFRESH  = 3'd7
  } kind_t;

  typedef enum logic [0:0] {
    REG_PITCH_FLOOR   = 1'b0,
    REG_PITCH_CEILING = 1'b1
  } reg_idx_t;

  localparam int TAB_LEN = 24;
  localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;
  localparam logic signed [15:0] FLOOR_RESET = -16'sd16202;
  localparam logic signed [15:0] CEILING_RESET = 16'sd16202;
  localparam logic signed [15:0] ONE_Q14 = 16'sd16384;

  // Arctangent of 2^-i in units of 2^32 per turn.
  function automatic logic [31:0] atan_lookup(input logic [4:0] i);
    logic [31:0] v;
    begin
      case (i)
        5'd0:  v = 32'h20000000;
        5'd1:  v = 32'h12E4051E;
        5'd2:  v = 32'h09FB385B;
        5'd3:  v = 32'h051111D4;
        5'd4:  v = 32'h028B0D43;
        5'd5:  v = 32'h0145D7E1;
        5'd6:  v = 32'h00A2F61E;
        5'd7:  v = 32'h00517C55;
        5'd8:  v = 32'h0028BE53;
        5'd9:  v = 32'h00145F2F;
        5'd10: v = 32'h000A2F98;
        5'd11: v = 32'h000517CC;
        5'd12: v = 32'h00028BE6;
        5'd13: v = 32'h000145F3;
        5'd14: v = 32'h0000A2FA;
        5'd15: v = 32'h0000517D;
        5'd16: v = 32'h000028BE;
        5'd17: v = 32'h0000145F;
        5'd18: v = 32'h00000A30;
        5'd19: v = 32'h00000518;
        5'd20: v = 32'h0000028C;
        5'd21: v = 32'h00000146;
        5'd22: v = 32'h000000A3;
        5'd23: v = 32'h00000051;
        default: v = 32'h0;
      endcase
      return v;
    end
  endfunction

  // Saturate a 34-bit sum to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [31:0] r;
    begin
      if (v > 34'sh0_7FFF_FFFF) r = 32'sh7FFF_FFFF;
      else if (v < -34'sh0_8000_0000) r = 32'sh8000_0000;
      else r = v[31:0];
      return r;
    end
  endfunction

endpackage

### rtl/eco_if.sv
// Valid/ready channel interfaces for the camera orientation unit.
// Depends on nothing; payload widths are fixed by the command format.
`timescale 1ns / 1ps
interface eco_cmd_if;
  logic              valid;
  logic              ready;
  logic [2:0]        kind;
  logic signed [31:0] new_x;
  logic signed [31:0] new_y;
  logic signed [31:0] new_z;
  logic signed [15:0] pitch_arg;
  logic signed [15:0] yaw_arg;
  logic signed [31:0] move_distance;
  modport source (output valid, kind, new_x, new_y, new_z, pitch_arg, yaw_arg,
                  move_distance, input ready);
  modport sink (input valid, kind, new_x, new_y, new_z, pitch_arg, yaw_arg,
                move_distance, output ready);
endinterface

interface eco_res_if;
  logic              valid;
  logic              ready;
  logic signed [31:0] cam_x;
  logic signed [31:0] cam_y;
  logic signed [31:0] cam_z;
  logic signed [15:0] cur_pitch;
  logic signed [15:0] cur_yaw;
  logic signed [31:0] aim_x;
  logic signed [31:0] aim_y;
  logic signed [31:0] aim_z;
  logic signed [15:0] up_x;
  logic signed [15:0] up_y;
  logic signed [15:0] up_z;
  modport source (output valid, cam_x, cam_y, cam_z, cur_pitch, cur_yaw, aim_x,
                  aim_y, aim_z, up_x, up_y, up_z, input ready);
  modport sink (input valid, cam_x, cam_y, cam_z, cur_pitch, cur_yaw, aim_x,
                aim_y, aim_z, up_x, up_y, up_z, output ready);
endinterface

interface eco_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### rtl/euler_camera_orientation_unit.sv
// Top level of the camera orientation unit: sequencer, shared CORDIC,
// shared multiplier and state. Depends on eco_pkg and the channel interfaces.
`timescale 1ns / 1ps
// One command word at a time. Each word runs the shared CORDIC for the pitch
// and then the yaw held before the command and forms the forward and up
// products through one shared 32x16 multiplier. It then applies the command;
// a move adds its three products to the position through the same
// multiplier. Finally it runs the CORDIC and the products again for the new
// angles and registers the result together with the target. Each angle runs
// through the single CORDIC stage, and this sets the cost. The next word is
// taken only once the result has been accepted.
module euler_camera_orientation_unit #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic clk,
  input  logic rst_n,
  eco_cmd_if.sink   in_ch,
  eco_res_if.source out_ch,
  eco_cfg_if.sink   cfg_ch
);

  localparam int STEPS = (CORDIC_STEPS > eco_pkg::TAB_LEN) ? eco_pkg::TAB_LEN
                                                            : CORDIC_STEPS;
  localparam logic [4:0] IT_LOAD    = 5'd31;
  localparam logic [4:0] IT_LAST    = 5'(STEPS);
  localparam logic [2:0] MUL_LAST   = 3'd3;
  localparam logic [2:0] MOVE_FIRST = 3'd4;
  localparam logic [2:0] MOVE_LAST  = 3'd6;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b000_0001,
    S_CORD  = 7'b000_0010,
    S_MUL   = 7'b000_0100,
    S_APPLY = 7'b000_1000,
    S_MOVE  = 7'b001_0000,
    S_AIM   = 7'b010_0000,
    S_OUT   = 7'b100_0000
  } state_t;

  state_t state_r, state_nxt;

  // Command word and state.
  eco_pkg::kind_t     kind_r;
  logic signed [31:0] nx_r, ny_r, nz_r, dist_r;
  logic signed [15:0] parg_r, yarg_r;
  logic signed [31:0] pos_r [3];
  logic signed [15:0] pitch_r, yaw_r;
  logic signed [15:0] floor_r, ceil_r;
  logic               phase_r;   // 0: vectors of old angles, 1: new angles

  // CORDIC datapath.
  logic signed [33:0] cx_r, cy_r, cz_r;
  logic [4:0]         it_r;
  logic               which_r;   // 0 pitch, 1 yaw
  logic               neg_r;
  logic signed [15:0] sp_r, cp_r, sy_r, cy2_r;

  // Multiplier sequencing.
  logic [2:0]         mstep_r;
  logic signed [31:0] ma;
  logic signed [15:0] mb16;
  logic signed [47:0] prod;
  logic signed [47:0] rnd;
  logic signed [15:0] q14;
  logic signed [15:0] fwd0_r, fwd1_r, upv0_r, upv1_r;
  logic signed [15:0] mvec_r [3];
  logic [1:0]         lane;
  logic               is_move;

  // Angle reduction, micro-rotation and pitch clamp signals.
  logic signed [15:0] ang;
  logic signed [16:0] red;
  logic               red_neg;
  logic signed [33:0] sx, sy, atn;
  logic signed [33:0] cx_nxt, cy_nxt, cz_nxt;
  logic signed [16:0] newp;
  logic signed [15:0] clp;

  // Rounding and clamping of the CORDIC outputs to Q2.14.
  function automatic logic signed [15:0] to_q14(input logic signed [33:0] v,
                                                input logic n);
    logic signed [33:0] r;
    logic signed [15:0] c;
    begin
      r = (v + 34'sd32768) >>> 16;
      if (r > 34'(eco_pkg::ONE_Q14)) c = eco_pkg::ONE_Q14;
      else if (r < -34'(eco_pkg::ONE_Q14)) c = -eco_pkg::ONE_Q14;
      else c = r[15:0];
      return n ? -c : c;
    end
  endfunction

  // Pitch clamp of a 17-bit candidate; the floor wins over the ceiling.
  function automatic logic signed [15:0] clampp(input logic signed [16:0] p,
                                                input logic signed [15:0] f,
                                                input logic signed [15:0] c);
    logic signed [16:0] t;
    begin
      t = p;
      if (t > 17'(c)) t = 17'(c);
      if (t < 17'(f)) t = 17'(f);
      return t[15:0];
    end
  endfunction

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      floor_r <= eco_pkg::FLOOR_RESET;
      ceil_r  <= eco_pkg::CEILING_RESET;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (eco_pkg::reg_idx_t'(cfg_ch.index))
        eco_pkg::REG_PITCH_FLOOR:   floor_r <= cfg_ch.data;
        eco_pkg::REG_PITCH_CEILING: ceil_r  <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // Angle reduction for the CORDIC start.
  always_comb begin
    ang = which_r ? yaw_r : pitch_r;
    red_neg = 1'b0;
    red = 17'(ang);
    if (ang > 16'sd16384) begin
      red = 17'(ang) - 17'sd32768;
      red_neg = 1'b1;
    end else if (ang < -16'sd16384) begin
      red = 17'(ang) + 17'sd32768;
      red_neg = 1'b1;
    end
  end

  // One CORDIC micro-rotation.
  always_comb begin
    sx  = cx_r >>> it_r;
    sy  = cy_r >>> it_r;
    atn = 34'(eco_pkg::atan_lookup(it_r));
    if (!cz_r[33]) begin
      cx_nxt = cx_r - sy;
      cy_nxt = cy_r + sx;
      cz_nxt = cz_r - atn;
    end else begin
      cx_nxt = cx_r + sy;
      cy_nxt = cy_r - sx;
      cz_nxt = cz_r + atn;
    end
  end

  // Shared multiplier: 32x16 signed, rounded to a shift of 14.
  always_comb begin
    ma   = 32'sd0;
    mb16 = 16'sd0;
    case (mstep_r)
      3'd0: begin ma = 32'(cp_r);  mb16 = sy_r;  end
      3'd1: begin ma = 32'(cp_r);  mb16 = cy2_r; end
      3'd2: begin ma = 32'(sp_r);  mb16 = sy_r;  end
      3'd3: begin ma = 32'(sp_r);  mb16 = cy2_r; end
      3'd4: begin ma = dist_r;     mb16 = mvec_r[0]; end
      3'd5: begin ma = dist_r;     mb16 = mvec_r[1]; end
      3'd6: begin ma = dist_r;     mb16 = mvec_r[2]; end
      default: ;
    endcase
    prod = 48'(ma) * 48'(mb16);
  end

  assign rnd  = (prod + 48'sd8192) >>> 14;
  assign q14  = rnd[15:0];
  assign lane = 2'(mstep_r - MOVE_FIRST);
  assign is_move = kind_r inside {eco_pkg::KIND_FORWARD, eco_pkg::KIND_RIGHT,
                                  eco_pkg::KIND_UP};

  // New pitch candidate, without wrap, and its clamp.
  always_comb begin
    if (kind_r == eco_pkg::KIND_ROTATE) newp = 17'(pitch_r) + 17'(parg_r);
    else newp = 17'(parg_r);
    clp = clampp(newp, floor_r, ceil_r);
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_ch.valid) state_nxt = S_CORD;
      S_CORD:  if (it_r == IT_LAST && which_r) state_nxt = S_MUL;
      S_MUL:   if (mstep_r == MUL_LAST) state_nxt = phase_r ? S_AIM : S_APPLY;
      S_APPLY: state_nxt = is_move ? S_MOVE : S_CORD;
      S_MOVE:  if (mstep_r == MOVE_LAST) state_nxt = S_CORD;
      S_AIM:   state_nxt = S_OUT;
      S_OUT:   if (out_ch.ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pos_r[0] <= '0; pos_r[1] <= '0; pos_r[2] <= '0;
      pitch_r <= '0;
      yaw_r   <= '0;
      it_r    <= IT_LOAD;
      which_r <= 1'b0;
      phase_r <= 1'b0;
      mstep_r <= '0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            kind_r <= eco_pkg::kind_t'(in_ch.kind);
            nx_r <= in_ch.new_x; ny_r <= in_ch.new_y; nz_r <= in_ch.new_z;
            parg_r <= in_ch.pitch_arg; yarg_r <= in_ch.yaw_arg;
            dist_r <= in_ch.move_distance;
            phase_r <= 1'b0;
            which_r <= 1'b0;
            it_r <= IT_LOAD;
          end
        end
        S_CORD: begin
          if (it_r == IT_LOAD) begin
            // Load the start vector for the selected angle.
            cx_r <= eco_pkg::GAIN_Q30;
            cy_r <= '0;
            cz_r <= 34'(red) <<< 16;
            neg_r <= red_neg;
            it_r <= 5'd0;
          end else if (it_r == IT_LAST) begin
            it_r <= IT_LOAD;
            which_r <= ~which_r;
            if (!which_r) begin
              sp_r <= to_q14(cy_r, neg_r);
              cp_r <= to_q14(cx_r, neg_r);
            end else begin
              sy_r  <= to_q14(cy_r, neg_r);
              cy2_r <= to_q14(cx_r, neg_r);
              mstep_r <= '0;
            end
          end else begin
            cx_r <= cx_nxt; cy_r <= cy_nxt; cz_r <= cz_nxt;
            it_r <= it_r + 5'd1;
          end
        end
        S_MUL: begin
          // Forward and up products of the current sines and cosines.
          case (mstep_r)
            3'd0: fwd0_r <= q14;
            3'd1: fwd1_r <= q14;
            3'd2: upv0_r <= -q14;
            default: upv1_r <= -q14;
          endcase
          mstep_r <= mstep_r + 3'd1;
        end
        S_APPLY: begin
          // Old-angle vectors are ready; apply the command.
          phase_r <= 1'b1;
          it_r <= IT_LOAD;
          which_r <= 1'b0;
          mstep_r <= MOVE_FIRST;
          unique case (kind_r)
            eco_pkg::KIND_SET_POS: begin
              pos_r[0] <= nx_r; pos_r[1] <= ny_r; pos_r[2] <= nz_r;
            end
            eco_pkg::KIND_SET_ROT: begin
              pitch_r <= clp; yaw_r <= yarg_r;
            end
            eco_pkg::KIND_ROTATE: begin
              pitch_r <= clp; yaw_r <= yaw_r + yarg_r;
            end
            eco_pkg::KIND_FORWARD: begin
              mvec_r[0] <= fwd0_r; mvec_r[1] <= fwd1_r; mvec_r[2] <= sp_r;
            end
            eco_pkg::KIND_RIGHT: begin
              mvec_r[0] <= cy2_r; mvec_r[1] <= -sy_r; mvec_r[2] <= '0;
            end
            eco_pkg::KIND_UP: begin
              mvec_r[0] <= upv0_r; mvec_r[1] <= upv1_r; mvec_r[2] <= cp_r;
            end
            eco_pkg::KIND_RST_ROT: begin
              pitch_r <= '0; yaw_r <= '0;
            end
            default: ;
          endcase
        end
        S_MOVE: begin
          // One axis per cycle, saturated to the signed 32-bit range.
          pos_r[lane] <= eco_pkg::sat32(34'(pos_r[lane]) + $signed(rnd[33:0]));
          mstep_r <= mstep_r + 3'd1;
        end
        default: ;
      endcase
    end
  end

  // Target and result register.
  always_ff @(posedge clk) begin
    if (state_r == S_AIM) begin
      out_ch.cam_x <= pos_r[0]; out_ch.cam_y <= pos_r[1]; out_ch.cam_z <= pos_r[2];
      out_ch.cur_pitch <= pitch_r; out_ch.cur_yaw <= yaw_r;
      out_ch.aim_x <= eco_pkg::sat32(34'(pos_r[0]) + (34'(fwd0_r) <<< 2));
      out_ch.aim_y <= eco_pkg::sat32(34'(pos_r[1]) + (34'(fwd1_r) <<< 2));
      out_ch.aim_z <= eco_pkg::sat32(34'(pos_r[2]) + (34'(sp_r) <<< 2));
      out_ch.up_x <= upv0_r; out_ch.up_y <= upv1_r; out_ch.up_z <= cp_r;
    end
  end
  assign out_ch.valid = (state_r == S_OUT);

endmodule

### rtl/eco_checker.sv
// Port-level checker for the camera orientation unit and its bind.
// Depends on the channel interfaces of the top level.
`timescale 1ns / 1ps
module eco_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic signed [15:0] cur_pitch
);
  // Never ready for a word while a result is pending.
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_valid && in_ready)) else $error("ready while result pending");
  // A result follows an accepted word, not in the next cycle.
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !out_valid) else $error("result too early");
  // A pending result holds until taken.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
  // Reported pitch stays within a quarter turn.
  a_pitch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (cur_pitch <= 16'sd16384 && cur_pitch >= -16'sd16384))
    else $error("pitch out of range");
endmodule

bind euler_camera_orientation_unit eco_checker u_eco_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .cur_pitch(out_ch.cur_pitch)
);

### tb/eco_camera_tb_if.sv
// Testbench types for the camera orientation unit: command and pose words.
// Depends on nothing; used by the top-level testbench.
`timescale 1ns / 1ps
package eco_tb_types;
  // One command word as the testbench holds it before driving.
  typedef struct packed {
    logic [2:0]         kind;
    logic signed [31:0] new_x;
    logic signed [31:0] new_y;
    logic signed [31:0] new_z;
    logic signed [15:0] pitch_arg;
    logic signed [15:0] yaw_arg;
    logic signed [31:0] move_distance;
  } cmd_word_t;

  // One result word: pose, target and up vector.
  typedef struct packed {
    logic signed [31:0] cam_x;
    logic signed [31:0] cam_y;
    logic signed [31:0] cam_z;
    logic signed [15:0] cur_pitch;
    logic signed [15:0] cur_yaw;
    logic signed [31:0] aim_x;
    logic signed [31:0] aim_y;
    logic signed [31:0] aim_z;
    logic signed [15:0] up_x;
    logic signed [15:0] up_y;
    logic signed [15:0] up_z;
  } pose_word_t;
endpackage

### tb/euler_camera_orientation_unit_tb.sv
// Testbench for the camera orientation unit: random and directed commands,
// a predictor of pose, target and up vector, and a scoreboard of pose words.
// Depends on eco_pkg, the channel interfaces and eco_tb_types.
`timescale 1ns / 1ps
module euler_camera_orientation_unit_tb;

  localparam int STEPS = 16;
  localparam int WORD_CYCLES = 4 * STEPS + 23;
  localparam int STALL_LIMIT = 20000;

  logic clk;
  logic rst_n;
  eco_cmd_if in_ch();
  eco_res_if out_ch();
  eco_cfg_if cfg_ch();

  euler_camera_orientation_unit #(.CORDIC_STEPS(STEPS)) i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  // Predictor state.
  logic signed [31:0] pos_q [3];
  logic signed [15:0] pitch_q;
  logic [15:0]        yaw_q;
  logic signed [15:0] floor_q;
  logic signed [15:0] ceil_q;

  eco_tb_types::cmd_word_t  cmd_queue[$];
  eco_tb_types::pose_word_t pose_queue[$];
  int errors;
  int idle_cycles;
  bit stim_done;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic longint asr64(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint rnd_shift(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic logic signed [31:0] clip32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic longint clip14(longint v);
    if (v > 16384) return 16384;
    if (v < -16384) return -16384;
    return v;
  endfunction

  function automatic logic [31:0] arctan_step(int i);
    logic [31:0] t [24] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};
    return t[i];
  endfunction

  // Sine and cosine of a binary angle in Q2.14 through the CORDIC iteration.
  task automatic angle_trig(input logic [15:0] ang, output longint sn, output longint cs);
    longint a, x, y, z, tx;
    bit flip;
    int n;
    a = longint'($signed(ang));
    flip = 1'b0;
    x = 652032874;
    y = 0;
    n = (STEPS > 24) ? 24 : STEPS;
    if (a > 16384) begin
      a -= 32768; flip = 1'b1;
    end else if (a < -16384) begin
      a += 32768; flip = 1'b1;
    end
    z = a * 65536;
    for (int i = 0; i < n; i++) begin
      if (z >= 0) begin
        tx = x - asr64(y, i); y = y + asr64(x, i); z -= longint'(arctan_step(i));
      end else begin
        tx = x + asr64(y, i); y = y - asr64(x, i); z += longint'(arctan_step(i));
      end
      x = tx;
    end
    x = clip14(rnd_shift(x, 16));
    y = clip14(rnd_shift(y, 16));
    if (flip) begin
      x = -x; y = -y;
    end
    cs = x;
    sn = y;
  endtask

  // Forward, right and up vectors of the held angles.
  task automatic camera_axes(output longint fwd[3], output longint rgt[3],
                             output longint upv[3]);
    longint sp, cp, sy, cy;
    angle_trig(pitch_q, sp, cp);
    angle_trig(yaw_q, sy, cy);
    fwd[0] = rnd_shift(cp * sy, 14); fwd[1] = rnd_shift(cp * cy, 14); fwd[2] = sp;
    rgt[0] = cy; rgt[1] = -sy; rgt[2] = 0;
    upv[0] = -rnd_shift(sp * sy, 14); upv[1] = -rnd_shift(sp * cy, 14); upv[2] = cp;
  endtask

  function automatic logic signed [15:0] pitch_limit(longint p);
    if (p > longint'(ceil_q)) p = ceil_q;
    if (p < longint'(floor_q)) p = floor_q;
    return p[15:0];
  endfunction

  // Apply one command to the predictor and queue the expected pose word.
  task automatic predict_pose(input eco_tb_types::cmd_word_t c);
    longint fwd[3], rgt[3], upv[3], vec[3];
    eco_tb_types::pose_word_t p;
    camera_axes(fwd, rgt, upv);
    vec = fwd;
    if (c.kind == eco_pkg::KIND_RIGHT) vec = rgt;
    if (c.kind == eco_pkg::KIND_UP) vec = upv;
    case (eco_pkg::kind_t'(c.kind))
      eco_pkg::KIND_SET_POS: begin
        pos_q[0] = c.new_x; pos_q[1] = c.new_y; pos_q[2] = c.new_z;
      end
      eco_pkg::KIND_SET_ROT: begin
        pitch_q = pitch_limit(longint'(c.pitch_arg));
        yaw_q = c.yaw_arg;
      end
      eco_pkg::KIND_ROTATE: begin
        pitch_q = pitch_limit(longint'(pitch_q) + longint'(c.pitch_arg));
        yaw_q = yaw_q + c.yaw_arg;
      end
      eco_pkg::KIND_FORWARD, eco_pkg::KIND_RIGHT, eco_pkg::KIND_UP: begin
        for (int i = 0; i < 3; i++)
          pos_q[i] = clip32(longint'(pos_q[i])
                            + rnd_shift(vec[i] * longint'(c.move_distance), 14));
      end
      eco_pkg::KIND_RST_ROT: begin
        pitch_q = '0; yaw_q = '0;
      end
      default: ;
    endcase
    camera_axes(fwd, rgt, upv);
    p.cam_x = pos_q[0]; p.cam_y = pos_q[1]; p.cam_z = pos_q[2];
    p.cur_pitch = pitch_q; p.cur_yaw = yaw_q;
    p.aim_x = clip32(longint'(pos_q[0]) + fwd[0] * 4);
    p.aim_y = clip32(longint'(pos_q[1]) + fwd[1] * 4);
    p.aim_z = clip32(longint'(pos_q[2]) + fwd[2] * 4);
    p.up_x = upv[0][15:0]; p.up_y = upv[1][15:0]; p.up_z = upv[2][15:0];
    pose_queue.push_back(p);
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d, expected %0d", what, got, want);
    errors++;
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // Driver: command words from the queue, with random gaps.
  int drive_gap;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.kind <= '0; in_ch.new_x <= '0; in_ch.new_y <= '0; in_ch.new_z <= '0;
      in_ch.pitch_arg <= '0; in_ch.yaw_arg <= '0; in_ch.move_distance <= '0;
      drive_gap <= 0;
    end else if (in_ch.valid && !in_ch.ready) begin
      // hold the word until it is taken
    end else begin
      if (in_ch.valid && in_ch.ready) predict_pose(cmd_queue.pop_front());
      if (drive_gap > 0 || cmd_queue.size() == 0 || (in_ch.valid && in_ch.ready)) begin
        in_ch.valid <= 1'b0;
        drive_gap <= (drive_gap > 0) ? drive_gap - 1 : gap_len();
      end else begin
        in_ch.valid <= 1'b1;
        in_ch.kind <= cmd_queue[0].kind;
        in_ch.new_x <= cmd_queue[0].new_x;
        in_ch.new_y <= cmd_queue[0].new_y;
        in_ch.new_z <= cmd_queue[0].new_z;
        in_ch.pitch_arg <= cmd_queue[0].pitch_arg;
        in_ch.yaw_arg <= cmd_queue[0].yaw_arg;
        in_ch.move_distance <= cmd_queue[0].move_distance;
      end
    end
  end

  // Monitor: receiver stalls and comparison of each pose word.
  int stall_len;
  always @(posedge clk) begin
    eco_tb_types::pose_word_t w, e;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_len <= 0;
      idle_cycles <= 0;
    end else begin
      idle_cycles <= ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                     ? 0 : idle_cycles + 1;
      if (out_ch.valid && out_ch.ready) begin
        w = '{out_ch.cam_x, out_ch.cam_y, out_ch.cam_z, out_ch.cur_pitch, out_ch.cur_yaw,
              out_ch.aim_x, out_ch.aim_y, out_ch.aim_z, out_ch.up_x, out_ch.up_y,
              out_ch.up_z};
        if (pose_queue.size() == 0) begin
          report_mismatch("unexpected pose word", 1, 0);
        end else begin
          e = pose_queue.pop_front();
          if (w.cam_x !== e.cam_x) report_mismatch("cam_x", w.cam_x, e.cam_x);
          if (w.cam_y !== e.cam_y) report_mismatch("cam_y", w.cam_y, e.cam_y);
          if (w.cam_z !== e.cam_z) report_mismatch("cam_z", w.cam_z, e.cam_z);
          if (w.cur_pitch !== e.cur_pitch)
            report_mismatch("cur_pitch", w.cur_pitch, e.cur_pitch);
          if (w.cur_yaw !== e.cur_yaw) report_mismatch("cur_yaw", w.cur_yaw, e.cur_yaw);
          if (w.aim_x !== e.aim_x) report_mismatch("aim_x", w.aim_x, e.aim_x);
          if (w.aim_y !== e.aim_y) report_mismatch("aim_y", w.aim_y, e.aim_y);
          if (w.aim_z !== e.aim_z) report_mismatch("aim_z", w.aim_z, e.aim_z);
          if (w.up_x !== e.up_x) report_mismatch("up_x", w.up_x, e.up_x);
          if (w.up_y !== e.up_y) report_mismatch("up_y", w.up_y, e.up_y);
          if (w.up_z !== e.up_z) report_mismatch("up_z", w.up_z, e.up_z);
        end
      end
      if (stall_len > 0) begin
        out_ch.ready <= 1'b0;
        stall_len <= stall_len - 1;
      end else begin
        out_ch.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_len <= gap_len();
      end
    end
  end

  // Watchdog on cycles without any accepted word.
  always @(posedge clk) begin
    if (rst_n && idle_cycles > STALL_LIMIT) begin
      $display("** euler_camera_orientation_unit: FAILED **");
      $finish;
    end
  end

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic eco_tb_types::cmd_word_t rand_cmd();
    eco_tb_types::cmd_word_t c;
    c.kind = 3'($urandom_range(0, 7));
    c.new_x = rand_coord(); c.new_y = rand_coord(); c.new_z = rand_coord();
    c.pitch_arg = ($urandom_range(0, 3) == 0) ? 16'($urandom())
                                               : 16'($urandom_range(0, 8000) - 4000);
    c.yaw_arg = 16'($urandom());
    c.move_distance = rand_coord();
    return c;
  endfunction

  function automatic eco_tb_types::cmd_word_t make_cmd(eco_pkg::kind_t k,
                                                       logic signed [31:0] v,
                                                       logic signed [15:0] p,
                                                       logic signed [15:0] y);
    eco_tb_types::cmd_word_t c;
    c = rand_cmd();
    c.kind = k;
    c.new_x = v; c.new_y = -v; c.new_z = v;
    c.pitch_arg = p; c.yaw_arg = y; c.move_distance = v;
    return c;
  endfunction

  // Wait until every pose word is back, then let the block settle.
  task automatic drain();
    while (cmd_queue.size() != 0 || in_ch.valid || pose_queue.size() != 0) @(posedge clk);
    repeat (WORD_CYCLES + 4) @(posedge clk);
  endtask

  task automatic write_reg(input eco_pkg::reg_idx_t idx, input logic signed [15:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    if (idx == eco_pkg::REG_PITCH_FLOOR) floor_q = v;
    else ceil_q = v;
  endtask

  initial begin
    logic signed [15:0] lo [5];
    logic signed [15:0] hi [5];
    lo = '{-16'sd16202, -16'sd16384, 16'sd0, -16'sd100, 16'sd500};
    hi = '{16'sd16202, 16'sd16384, 16'sd0, 16'sd100, -16'sd500};
    errors = 0;
    stim_done = 1'b0;
    pos_q = '{default: '0};
    pitch_q = '0; yaw_q = '0;
    floor_q = eco_pkg::FLOOR_RESET; ceil_q = eco_pkg::CEILING_RESET;
    rst_n = 1'b0;
    cfg_ch.valid = 1'b0; cfg_ch.index = '0; cfg_ch.data = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: every kind, extreme values, clamps, wraps and saturation.
    cmd_queue.push_back(make_cmd(eco_pkg::KIND_REFRESH, 32'sd0, 16'sd0, 16'sd0));
    cmd_queue.push_back(make_cmd(eco_pkg::KIND_SET_POS, 32'sh7FFF_FFFF, 16'sd0, 16'sd0));
    cmd_queue.push_back(make_cmd(eco_pkg::KIND_FORWARD, 32'sh7FFF_FFFF, 16'sd0, 16'sd0));
    cmd_queue.push_back(make_cmd(eco_pkg::KIND_SET_ROT, 32'sd0, 16'sh7FFF, 16'sh7FFF));
    cmd_queue.push_back(make_cmd(eco_pkg::KIND_UP, 32'sh8000_0000, 16'sd0, 16'sd0));
    cmd_queue.push_back(make_cmd(eco_pkg::KIND_SET_ROT, 32'sd0, 16'sh8000, 16'sh8000));
    cmd_queue.push_back(make_cmd(eco_pkg::KIND_RIGHT, 32'sh8000_0000, 16'sd0, 16'sd0));
    cmd_queue.push_back(make_cmd(eco_pkg::KIND_ROTATE, 32'sd0, 16'sh7FFF, 16'sh7FFF));
    cmd_queue.push_back(make_cmd(eco_pkg::KIND_ROTATE, 32'sd0, 16'sh8000, 16'sh7FFF));
    cmd_queue.push_back(make_cmd(eco_pkg::KIND_SET_ROT, 32'sd0, 16'sd16385, -16'sd16385));
    cmd_queue.push_back(make_cmd(eco_pkg::KIND_SET_ROT, 32'sd0, -16'sd16384, 16'sd16384));
    cmd_queue.push_back(make_cmd(eco_pkg::KIND_FORWARD, 32'sh0001_0000, 16'sd0, 16'sd0));
    cmd_queue.push_back(make_cmd(eco_pkg::KIND_RST_ROT, 32'sd0, 16'sd0, 16'sd0));
    cmd_queue.push_back(make_cmd(eco_pkg::KIND_SET_POS, 32'sh8000_0000, 16'sd0, 16'sd0));
    cmd_queue.push_back(make_cmd(eco_pkg::KIND_UP, 32'sh8000_0000, 16'sd0, 16'sd0));
    cmd_queue.push_back(make_cmd(eco_pkg::KIND_RIGHT, -32'sh0001_0000, 16'sd0, 16'sd0));
    drain();

    // Random phases under several limit settings, extremes and inverted limits among them.
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(eco_pkg::REG_PITCH_FLOOR, lo[ph]);
      write_reg(eco_pkg::REG_PITCH_CEILING, hi[ph]);
      repeat (340) cmd_queue.push_back(rand_cmd());
      if (ph == 2)
        cmd_queue.push_back(make_cmd(eco_pkg::KIND_RST_ROT, 32'sd0, 16'sd0, 16'sd0));
      drain();
    end
    stim_done = 1'b1;
  end

  // Final verdict once all stimulus is done.
  always @(posedge clk) begin
    if (stim_done) begin
      if (errors == 0 && pose_queue.size() == 0)
        $display("** euler_camera_orientation_unit: PASSED **");
      else
        $display("** euler_camera_orientation_unit: FAILED **");
      $finish;
    end
  end
endmodule
